[src/savcg_pkg.sv]
package savcg_pkg;

	localparam int GLYPH_ENTRIES = 2048;
	localparam int GLYPH_AW = $clog2(GLYPH_ENTRIES);

	// request codes
	localparam logic [1:0] REQ_LINE  = 2'd0;
	localparam logic [1:0] REQ_CELL  = 2'd1;
	localparam logic [1:0] REQ_GLYPH = 2'd2;

	// attribute groups, bits 4..3 of an attribute byte
	localparam logic [1:0] ATTR_INK   = 2'd0;
	localparam logic [1:0] ATTR_FLAGS = 2'd1;
	localparam logic [1:0] ATTR_PAPER = 2'd2;
	localparam logic [1:0] ATTR_MODE  = 2'd3;

	// text flag bits, mode bit and frame counter bit
	localparam int FLAG_ALT   = 0;
	localparam int FLAG_DBL   = 1;
	localparam int FLAG_BLINK = 2;
	localparam int MODE_HIRES = 2;
	localparam int FRAME_BLINK = 4;

	localparam logic [15:0] TEXT_BASE  = 16'hBB80;
	localparam logic [15:0] HIRES_BASE = 16'hA000;
	localparam logic [7:0]  LINES      = 8'd224;
	localparam logic [7:0]  MAIN_LINES = 8'd200;
	localparam logic [5:0]  COLUMNS    = 6'd40;

	localparam logic [2:0] MODE_RESET = 3'd2;
	localparam logic [2:0] INK_RESET  = 3'd7;

	typedef struct packed {
		logic        is_cell;
		logic        attr;
		logic        hires;
		logic        glyph;
		logic [2:0]  fg;
		logic [2:0]  bg;
		logic [5:0]  bits;
		logic [15:0] addr;
	} cell_t;

	// glyph index folded onto the store depth
	function automatic logic [GLYPH_AW-1:0] glyph_wrap(input logic [10:0] idx);
		logic [12:0] v;
		v = 13'(idx);
		if (v >= 13'(GLYPH_ENTRIES)) begin
			v = v - 13'(GLYPH_ENTRIES);
		end
		return GLYPH_AW'(v);
	endfunction

endpackage

[src/savcg_req_if.sv]
interface savcg_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  req_type;
	logic [7:0]  line_number;
	logic [5:0]  column;
	logic [7:0]  video_byte;
	logic [10:0] glyph_index;
	logic [5:0]  glyph_bits;

	modport source(output valid, req_type, line_number, column, video_byte, glyph_index,
		glyph_bits, input ready);
	modport sink(input valid, req_type, line_number, column, video_byte, glyph_index,
		glyph_bits, output ready);
endinterface

[src/savcg_res_if.sv]
interface savcg_res_if;
	logic        valid;
	logic        ready;
	logic        pixels_valid;
	logic [17:0] pixel_colors;
	logic [15:0] fetch_address;
	logic        attribute_cell;
	logic        hires_cell;

	modport source(output valid, pixels_valid, pixel_colors, fetch_address, attribute_cell,
		hires_cell, input ready);
	modport sink(input valid, pixels_valid, pixel_colors, fetch_address, attribute_cell,
		hires_cell, output ready);
endinterface

[src/serial_attribute_video_cell_generator_unit.sv]
// Serial-attribute cell generator: every request (line start, cell render, glyph store
// write) yields exactly one result via stage one and stage two, and a new request is
// taken every cycle while the result side keeps up. Attribute state and the glyph store
// are updated at acceptance, so a cell sees everything accepted before it. Throughput is
// one request per clock, set by the single write and single registered read of the
// 2048 x 6 glyph store. The glyph store has no reset: render only entries already written.
module serial_attribute_video_cell_generator_unit (
	input  logic        clk,
	input  logic        arst_n,
	savcg_req_if.sink   req,
	savcg_res_if.source rsp
);
	import savcg_pkg::*;

	logic       s1_valid;
	logic       adv;
	cell_t      cell_s1;
	logic [5:0] glyph_s1;

	savcg_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (req),
		.adv      (adv),
		.s1_valid (s1_valid),
		.cell_s1  (cell_s1),
		.glyph_s1 (glyph_s1)
	);

	savcg_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.s1_valid (s1_valid),
		.cell_s1  (cell_s1),
		.glyph_s1 (glyph_s1),
		.adv      (adv),
		.rsp      (rsp)
	);

endmodule

[src/savcg_front.sv]
module savcg_front (
	input  logic            clk,
	input  logic            arst_n,
	savcg_req_if.sink       req,
	input  logic            adv,
	output logic            s1_valid,
	output savcg_pkg::cell_t cell_s1,
	output logic [5:0]      glyph_s1
);
	import savcg_pkg::*;

	logic [2:0] mode_q;
	logic [2:0] ink_q;
	logic [2:0] paper_q;
	logic [2:0] flags_q;
	logic [7:0] frame_q;
	logic [7:0] line_q;
	logic       s1_valid_q;

	logic [5:0] glyph_mem [GLYPH_ENTRIES];

	logic        accept;
	logic        is_cell;
	logic        attr_byte;
	logic        hires;
	logic        inv;
	logic        glyph_inv;
	logic [1:0]  sel;
	logic [2:0]  val;
	logic [2:0]  paper_new;
	logic [2:0]  row;
	logic [10:0] rd_idx;
	logic [15:0] addr;
	cell_t       cell_d;

	assign req.ready = !s1_valid_q || adv;
	assign accept    = req.valid && req.ready;
	assign s1_valid  = s1_valid_q;

	always_comb begin
		is_cell   = (req.req_type == REQ_CELL) && (req.column < COLUMNS);
		attr_byte = (req.video_byte[6:5] == 2'b00);
		hires     = (line_q < MAIN_LINES) && mode_q[MODE_HIRES];
		inv       = req.video_byte[7];
		sel       = req.video_byte[4:3];
		val       = req.video_byte[2:0];
		glyph_inv = inv ^ (flags_q[FLAG_BLINK] & frame_q[FRAME_BLINK]);
		row       = flags_q[FLAG_DBL] ? line_q[3:1] : line_q[2:0];
		rd_idx    = {flags_q[FLAG_ALT], req.video_byte[6:0], row};
		paper_new = (attr_byte && sel == ATTR_PAPER) ? val : paper_q;
		// y*40 as (y<<5)+(y<<3)
		if (hires) begin
			addr = HIRES_BASE + (16'(line_q) << 5) + (16'(line_q) << 3) + 16'(req.column);
		end else begin
			addr = TEXT_BASE + (16'(line_q[7:3]) << 5) + (16'(line_q[7:3]) << 3)
				+ 16'(req.column);
		end

		cell_d = '0;
		if (is_cell) begin
			cell_d.is_cell = 1'b1;
			cell_d.addr    = addr;
			if (attr_byte) begin
				cell_d.attr = 1'b1;
				cell_d.fg   = paper_new ^ {3{inv}};
				cell_d.bg   = paper_new ^ {3{inv}};
			end else if (hires) begin
				cell_d.hires = 1'b1;
				cell_d.fg    = ink_q ^ {3{inv}};
				cell_d.bg    = paper_q ^ {3{inv}};
				cell_d.bits  = req.video_byte[5:0];
			end else begin
				cell_d.glyph = 1'b1;
				cell_d.fg    = ink_q ^ {3{glyph_inv}};
				cell_d.bg    = paper_q ^ {3{glyph_inv}};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= MODE_RESET;
			ink_q   <= INK_RESET;
			paper_q <= 3'd0;
			flags_q <= 3'd0;
			frame_q <= 8'd0;
			line_q  <= 8'd0;
		end else if (accept) begin
			unique case (req.req_type)
				REQ_LINE: begin
					if (req.line_number < LINES) begin
						if (req.line_number == 8'd0) begin
							frame_q <= frame_q + 8'd1;
						end
						flags_q <= 3'd0;
						ink_q   <= INK_RESET;
						paper_q <= 3'd0;
						line_q  <= req.line_number;
					end
				end
				REQ_CELL: begin
					if (is_cell && attr_byte) begin
						unique case (sel)
							ATTR_INK:   ink_q   <= val;
							ATTR_FLAGS: flags_q <= val;
							ATTR_PAPER: paper_q <= val;
							ATTR_MODE:  mode_q  <= val;
							default:    ;
						endcase
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (req.ready) begin
			s1_valid_q <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cell_s1 <= cell_d;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && req.req_type == REQ_GLYPH) begin
			glyph_mem[glyph_wrap(req.glyph_index)] <= req.glyph_bits;
		end
	end

	// read data held with the stage while it stalls
	always_ff @(posedge clk) begin
		if (accept) begin
			glyph_s1 <= glyph_mem[glyph_wrap(rd_idx)];
		end
	end

	a_frame_step: assert property (@(posedge clk) disable iff (!arst_n)
		accept && req.req_type == REQ_LINE && req.line_number == 8'd0
		|=> frame_q == 8'($past(frame_q) + 8'd1))
		else $error("frame counter did not advance on line zero");

	a_line_reset: assert property (@(posedge clk) disable iff (!arst_n)
		accept && req.req_type == REQ_LINE && req.line_number < LINES
		|=> ink_q == INK_RESET && paper_q == 3'd0 && flags_q == 3'd0)
		else $error("line start did not reset attributes");

	// store data only matters for glyph cells
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		s1_valid_q && !adv |=> s1_valid_q && $stable(cell_s1)
		&& (!cell_s1.glyph || $stable(glyph_s1)))
		else $error("stage one lost its request while stalled");

endmodule

[src/savcg_back.sv]
module savcg_back (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s1_valid,
	input  savcg_pkg::cell_t cell_s1,
	input  logic [5:0]       glyph_s1,
	output logic             adv,
	savcg_res_if.source      rsp
);
	import savcg_pkg::*;

	logic        valid_s2;
	logic        pixels_valid_s2;
	logic [17:0] colors_s2;
	logic [15:0] addr_s2;
	logic        attr_s2;
	logic        hires_s2;

	logic [5:0]  bits;
	logic [17:0] colors;

	assign adv = s1_valid && (!valid_s2 || rsp.ready);

	always_comb begin
		bits = cell_s1.glyph ? glyph_s1 : cell_s1.bits;
		for (int i = 0; i < 6; i++) begin
			colors[i*3 +: 3] = bits[i] ? cell_s1.fg : cell_s1.bg;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (!valid_s2 || rsp.ready) begin
			valid_s2 <= s1_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			pixels_valid_s2 <= cell_s1.is_cell;
			colors_s2       <= colors;
			addr_s2         <= cell_s1.addr;
			attr_s2         <= cell_s1.attr;
			hires_s2        <= cell_s1.hires;
		end
	end

	assign rsp.valid          = valid_s2;
	assign rsp.pixels_valid   = pixels_valid_s2;
	assign rsp.pixel_colors   = colors_s2;
	assign rsp.fetch_address  = addr_s2;
	assign rsp.attribute_cell = attr_s2;
	assign rsp.hires_cell     = hires_s2;

	a_blank_result: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && !pixels_valid_s2
		|-> colors_s2 == 18'd0 && addr_s2 == 16'd0 && !attr_s2 && !hires_s2)
		else $error("non-cell result carries data");

	a_kind_excl: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> !(attr_s2 && hires_s2))
		else $error("cell flagged both attribute and hires");

	a_adv_lands: assert property (@(posedge clk) disable iff (!arst_n)
		adv |=> valid_s2)
		else $error("request advanced but no result held");

endmodule

[tb/savcg_checker.sv]
`timescale 1ns / 100ps
module savcg_checker (
	input  logic clk,
	input  logic arst_n,
	savcg_req_if req,
	savcg_res_if rsp,
	output int   fail_count,
	output int   pending_cells
);
	import savcg_pkg::*;

	typedef struct packed {
		logic        pixels_valid;
		logic [17:0] colors;
		logic [15:0] addr;
		logic        attr;
		logic        hires;
	} cell_out_t;

	logic [2:0] mode_q;
	logic [2:0] ink_q;
	logic [2:0] paper_q;
	logic [2:0] flags_q;
	logic [7:0] frame_q;
	logic [7:0] line_q;
	logic [5:0] glyph_mem [GLYPH_ENTRIES];
	cell_out_t  cells_due [$];

	initial begin
		fail_count = 0;
		pending_cells = 0;
	end

	// six pixels, leftmost in the top three bits
	function automatic logic [17:0] spread_row(logic [5:0] bits, logic [2:0] fg, logic [2:0] bg);
		logic [17:0] acc;
		acc = '0;
		for (int i = 5; i >= 0; i--) begin
			acc = {acc[14:0], bits[i] ? fg : bg};
		end
		return acc;
	endfunction

	// updates the attribute state and returns the cell this request should produce
	function automatic cell_out_t predict_request(logic [1:0] kind, logic [7:0] line,
		logic [5:0] col, logic [7:0] vbyte, logic [10:0] gidx, logic [5:0] gbits);
		cell_out_t   res;
		logic        hires;
		logic        inv;
		logic [2:0]  row;
		logic [10:0] idx;
		res = '0;
		case (kind)
			REQ_LINE: begin
				if (line < LINES) begin
					if (line == 8'd0) begin
						frame_q = frame_q + 8'd1;
					end
					flags_q = '0;
					ink_q = INK_RESET;
					paper_q = '0;
					line_q = line;
				end
			end
			REQ_GLYPH: begin
				glyph_mem[gidx % GLYPH_ENTRIES] = gbits;
			end
			REQ_CELL: begin
				if (col < COLUMNS) begin
					// mode as it stood before this byte is decoded
					hires = (line_q < MAIN_LINES) && mode_q[MODE_HIRES];
					res.addr = hires ? HIRES_BASE + 16'(line_q) * 16'(COLUMNS) + 16'(col)
						: TEXT_BASE + 16'(line_q >> 3) * 16'(COLUMNS) + 16'(col);
					inv = vbyte[7];
					if (vbyte[6:5] == 2'b00) begin
						case (vbyte[4:3])
							ATTR_INK:   ink_q = vbyte[2:0];
							ATTR_FLAGS: flags_q = vbyte[2:0];
							ATTR_PAPER: paper_q = vbyte[2:0];
							default:    mode_q = vbyte[2:0];
						endcase
						res.colors = spread_row(6'd0, 3'd0, paper_q ^ {3{inv}});
						res.attr = 1'b1;
					end else if (hires) begin
						res.colors = spread_row(vbyte[5:0], ink_q ^ {3{inv}}, paper_q ^ {3{inv}});
						res.hires = 1'b1;
					end else begin
						if (flags_q[FLAG_BLINK] && frame_q[FRAME_BLINK]) begin
							inv = !inv;
						end
						row = flags_q[FLAG_DBL] ? line_q[3:1] : line_q[2:0];
						idx = {flags_q[FLAG_ALT], vbyte[6:0], row};
						res.colors = spread_row(glyph_mem[idx % GLYPH_ENTRIES],
							ink_q ^ {3{inv}}, paper_q ^ {3{inv}});
					end
					res.pixels_valid = 1'b1;
				end
			end
			default: ;
		endcase
		return res;
	endfunction

	task automatic compare_field(string name, logic [17:0] want, logic [17:0] got);
		if (got !== want) begin
			fail_count++;
			$display("%0t: %s expected %h actual %h", $time, name, want, got);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin : scoreboard
		cell_out_t want;
		if (!arst_n) begin
			mode_q = MODE_RESET;
			ink_q = INK_RESET;
			paper_q = '0;
			flags_q = '0;
			frame_q = '0;
			line_q = '0;
			cells_due.delete();
			pending_cells = 0;
		end else begin
			if (rsp.valid && rsp.ready) begin
				if (cells_due.size() == 0) begin
					fail_count++;
					$display("%0t: result with no request pending, expected none actual %h %h",
						$time, rsp.pixel_colors, rsp.fetch_address);
				end else begin
					want = cells_due.pop_front();
					compare_field("pixels_valid", 18'(want.pixels_valid), 18'(rsp.pixels_valid));
					compare_field("pixel_colors", want.colors, rsp.pixel_colors);
					compare_field("fetch_address", 18'(want.addr), 18'(rsp.fetch_address));
					compare_field("attribute_cell", 18'(want.attr), 18'(rsp.attribute_cell));
					compare_field("hires_cell", 18'(want.hires), 18'(rsp.hires_cell));
				end
			end
			if (req.valid && req.ready) begin
				cells_due.push_back(predict_request(req.req_type, req.line_number, req.column,
					req.video_byte, req.glyph_index, req.glyph_bits));
			end
			pending_cells = cells_due.size();
		end
	end

endmodule

[tb/serial_attribute_video_cell_generator_unit_tb.sv]
`timescale 1ns / 100ps
module serial_attribute_video_cell_generator_unit_tb;
	import savcg_pkg::*;

	localparam logic [1:0] REQ_UNUSED = 2'd3;
	localparam int ITEM_TARGET = 1750;

	typedef struct packed {
		logic [1:0]  kind;
		logic [7:0]  line;
		logic [5:0]  col;
		logic [7:0]  vbyte;
		logic [10:0] gidx;
		logic [5:0]  gbits;
	} request_t;

	logic        clk = 1'b1;
	logic        arst_n;
	int          fail_count;
	int          pending_cells;
	int          burst_left;
	int          cycle_count = 0;
	logic [15:0] char_rows [128];
	int          loaded_chars [$];

	savcg_req_if req ();
	savcg_res_if rsp ();

	serial_attribute_video_cell_generator_unit u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp)
	);

	savcg_checker u_chk (
		.clk           (clk),
		.arst_n        (arst_n),
		.req           (req),
		.rsp           (rsp),
		.fail_count    (fail_count),
		.pending_cells (pending_cells)
	);

	always begin
		#6 clk = 1'b0;
		#6 clk = 1'b1;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
	end

	initial begin
		#5_000_000;
		$display("== FAIL ==");
		$finish;
	end

	// result side: stall rate redrawn at random from four levels, plus two long hold-offs
	initial begin : result_side
		int stall_pct;
		int hold;
		rsp.ready = 1'b0;
		stall_pct = 0;
		hold = 0;
		forever begin
			@(negedge clk);
			if (cycle_count % 256 == 0) begin
				case ($urandom_range(3))
					0: stall_pct = 0;
					1: stall_pct = 20;
					2: stall_pct = 60;
					default: stall_pct = 90;
				endcase
			end
			if (cycle_count == 1500 || cycle_count == 4200) begin
				hold = 120;
			end
			if (hold > 0) begin
				hold--;
				rsp.ready <= 1'b0;
			end else begin
				rsp.ready <= ($urandom_range(99) >= stall_pct);
			end
		end
	end

	function automatic request_t any_request();
		request_t r;
		r.kind = 2'($urandom);
		r.line = 8'($urandom);
		r.col = 6'($urandom);
		r.vbyte = 8'($urandom);
		r.gidx = 11'($urandom);
		r.gbits = 6'($urandom);
		return r;
	endfunction

	function automatic request_t line_request(logic [7:0] line);
		request_t r;
		r = any_request();
		r.kind = REQ_LINE;
		r.line = line;
		return r;
	endfunction

	function automatic request_t cell_request(logic [5:0] col, logic [7:0] vbyte);
		request_t r;
		r = any_request();
		r.kind = REQ_CELL;
		r.col = col;
		r.vbyte = vbyte;
		return r;
	endfunction

	function automatic request_t glyph_request(logic [10:0] gidx, logic [5:0] gbits);
		request_t r;
		r = any_request();
		r.kind = REQ_GLYPH;
		r.gidx = gidx;
		r.gbits = gbits;
		return r;
	endfunction

	// a char becomes usable once all 8 rows of both sets are written
	function automatic void note_glyph(logic [10:0] gidx);
		logic [6:0] ch;
		logic       was_full;
		ch = gidx[9:3];
		was_full = &char_rows[ch];
		char_rows[ch][{gidx[10], gidx[2:0]}] = 1'b1;
		if (!was_full && (&char_rows[ch]) && ch[6:5] != 2'b00) begin
			loaded_chars.push_back(int'(ch));
		end
	endfunction

	// called at a falling edge, returns at the falling edge after acceptance
	task automatic send_request(input request_t r);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 6);
			burst_left = $urandom_range(1, 24);
			if (gap > 0) begin
				req.valid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
		burst_left--;
		req.valid <= 1'b1;
		req.req_type <= r.kind;
		req.line_number <= r.line;
		req.column <= r.col;
		req.video_byte <= r.vbyte;
		req.glyph_index <= r.gidx;
		req.glyph_bits <= r.gbits;
		do @(posedge clk); while (!req.ready);
		@(negedge clk);
		if (r.kind == REQ_GLYPH) begin
			note_glyph(r.gidx);
		end
	endtask

	task automatic load_char();
		logic [6:0] ch;
		ch = 7'($urandom_range(32, 127));
		for (int s = 0; s < 2; s++) begin
			for (int row = 0; row < 8; row++) begin
				send_request(glyph_request({1'(s), ch, 3'(row)}, 6'($urandom)));
			end
		end
	endtask

	// attribute byte, or a char whose glyph rows are all in the store
	function automatic logic [7:0] pick_video_byte();
		if (loaded_chars.size() == 0 || $urandom_range(99) < 30) begin
			return {1'($urandom), 2'b00, 5'($urandom)};
		end
		return {1'($urandom), 7'(loaded_chars[$urandom_range(loaded_chars.size() - 1)])};
	endfunction

	initial begin : stimulus
		int items;
		int ncells;
		int first_col;
		request_t r;
		for (int i = 0; i < 128; i++) begin
			char_rows[i] = '0;
		end
		burst_left = 0;
		arst_n = 1'b0;
		req.valid = 1'b0;
		req.req_type = REQ_LINE;
		req.line_number = '0;
		req.column = '0;
		req.video_byte = '0;
		req.glyph_index = '0;
		req.glyph_bits = '0;
		repeat (4) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed: store extremes, render before any line start, range edges,
		// alternate set, double height, inversion, hires to text boundary
		send_request(glyph_request(11'd2047, 6'h3F));
		send_request(glyph_request(11'd0, 6'h00));
		send_request(glyph_request(11'd1016, 6'h2A));
		send_request(glyph_request(11'd2043, 6'h15));
		send_request(cell_request(6'd0, 8'h7F));
		send_request(line_request(8'd0));
		send_request(cell_request(6'd39, 8'hFF));
		send_request(cell_request(6'd40, 8'h7F));
		send_request(cell_request(6'd63, 8'h00));
		r = any_request();
		r.kind = REQ_UNUSED;
		send_request(r);
		send_request(line_request(8'd224));
		send_request(line_request(8'd255));
		send_request(line_request(8'd7));
		send_request(cell_request(6'd1, 8'h09));
		send_request(cell_request(6'd2, 8'h7F));
		send_request(cell_request(6'd3, 8'h0B));
		send_request(cell_request(6'd4, 8'h7F));
		send_request(cell_request(6'd5, 8'h87));
		send_request(cell_request(6'd6, 8'h95));
		send_request(cell_request(6'd7, 8'h1E));
		send_request(cell_request(6'd8, 8'hE5));
		send_request(cell_request(6'd9, 8'h7F));
		send_request(line_request(8'd199));
		send_request(cell_request(6'd39, 8'h55));
		send_request(line_request(8'd200));
		send_request(cell_request(6'd0, 8'h7F));
		send_request(cell_request(6'd1, 8'h1A));
		send_request(line_request(8'd223));
		send_request(cell_request(6'd39, 8'h9A));

		items = 0;
		repeat (4) begin
			load_char();
			items += 16;
		end
		while (items < ITEM_TARGET) begin
			case ($urandom_range(99)) inside
				[0:5]: begin
					load_char();
					items += 16;
				end
				[6:13]: begin
					case ($urandom_range(3))
						0: begin
							r = any_request();
							r.kind = REQ_UNUSED;
							send_request(r);
						end
						1: send_request(line_request(8'($urandom_range(224, 255))));
						2: send_request(cell_request(6'($urandom_range(40, 63)), 8'($urandom)));
						default: begin
							send_request(glyph_request(11'($urandom), 6'($urandom)));
							items++;
						end
					endcase
				end
				default: begin
					// one scanline: line start, then a run of cells left to right
					if ($urandom_range(99) < 40) begin
						send_request(line_request(8'd0));
					end else begin
						send_request(line_request(8'($urandom_range(223))));
					end
					ncells = ($urandom_range(7) == 0) ? 40 : $urandom_range(1, 10);
					first_col = $urandom_range(0, 40 - ncells);
					for (int c = 0; c < ncells; c++) begin
						send_request(cell_request(6'(first_col + c), pick_video_byte()));
					end
					items += 1 + ncells;
				end
			endcase
		end
		req.valid <= 1'b0;

		wait (pending_cells == 0);
		repeat (20) @(posedge clk);
		if (fail_count == 0 && pending_cells == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule
